>>> src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric second-order compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int unsigned COEFF_W    = 16;
   localparam int unsigned CSR_INDEX_W = 3;

   // Calibration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SENS        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENS_TEMP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_TEMP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_TEMP    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_SLOPE  = 3'd5;

   typedef struct packed {
      logic [COEFF_W-1:0] sens;
      logic [COEFF_W-1:0] offset;
      logic [COEFF_W-1:0] sens_temp;
      logic [COEFF_W-1:0] offset_temp;
      logic [COEFF_W-1:0] ref_temp;
      logic [COEFF_W-1:0] temp_slope;
   } coeff_type;

endpackage

>>> src/bsc_csr.sv
// ----------------------------------------------------------------------------
// bsc_csr
// Calibration word registers, written through the csr channel.
// ----------------------------------------------------------------------------
module bsc_csr
   import bsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEFF_W-1:0]     csr_wdata,
   output coeff_type              coeff
);

   coeff_type coeff_ff;
   coeff_type coeff_in;

   assign csr_ready = 1'b1;
   assign coeff     = coeff_ff;

   always_comb begin
      coeff_in = coeff_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SENS:        coeff_in.sens        = csr_wdata;
            CSR_OFFSET:      coeff_in.offset      = csr_wdata;
            CSR_SENS_TEMP:   coeff_in.sens_temp   = csr_wdata;
            CSR_OFFSET_TEMP: coeff_in.offset_temp = csr_wdata;
            CSR_REF_TEMP:    coeff_in.ref_temp    = csr_wdata;
            CSR_TEMP_SLOPE:  coeff_in.temp_slope  = csr_wdata;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

endmodule

>>> src/baro_sensor_second_order_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_second_order_compensation
// Raw pressure/temperature pair in, compensated pressure and temperature out.
// ----------------------------------------------------------------------------
// The block accepts one item per clock when the output side does not stall.
// It is an eight-stage pipeline: offset subtract, the three calibration
// products and the square of dt, the first-order terms, the square of the
// temperature deviation, the second-order corrections, the 24x40 pressure
// product taken as two partial products, their merge, and the final offset
// subtract in the output register. Each stage holds its item until the next
// one is free, so empty stages fill while a result waits. Calibration words
// are to be written through the csr channel only while no item is in flight;
// the block itself does not enforce this.
module baro_sensor_second_order_compensation
   import bsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [47:0]            req_tdata,   // pressure_raw[23:0], temperature_raw[47:24]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [55:0]            rsp_tdata,   // pressure_comp[31:0], temperature_centi[50:32]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEFF_W-1:0]     csr_wdata
);

   localparam int unsigned NUM_STAGES = 8;
   localparam logic signed [18:0] TEMP_BASE = 19'sd2000;

   coeff_type coeff;

   bsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coeff     (coeff)
   );

   // ---------------------------------------------------------------- control
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------- stage 0
   logic [23:0]        s0_p_ff,  s0_p_in;
   logic signed [24:0] s0_dt_ff, s0_dt_in;

   always_comb begin
      s0_p_in  = req_tdata[23:0];
      s0_dt_in = $signed({1'b0, req_tdata[47:24]}) - $signed({1'b0, coeff.ref_temp, 8'h00});
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_p_ff  <= s0_p_in;
         s0_dt_ff <= s0_dt_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [23:0]        s1_p_ff,      s1_p_in;
   logic signed [41:0] s1_prod_t_ff, s1_prod_t_in;
   logic signed [41:0] s1_prod_o_ff, s1_prod_o_in;
   logic signed [41:0] s1_prod_s_ff, s1_prod_s_in;
   logic [47:0]        s1_dtsq_ff,   s1_dtsq_in;
   logic signed [49:0] dtsq_full;

   always_comb begin
      s1_p_in      = s0_p_ff;
      s1_prod_t_in = s0_dt_ff * $signed({1'b0, coeff.temp_slope});
      s1_prod_o_in = s0_dt_ff * $signed({1'b0, coeff.offset_temp});
      s1_prod_s_in = s0_dt_ff * $signed({1'b0, coeff.sens_temp});
      dtsq_full    = s0_dt_ff * s0_dt_ff;
      s1_dtsq_in   = dtsq_full[47:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_p_ff      <= s1_p_in;
         s1_prod_t_ff <= s1_prod_t_in;
         s1_prod_o_ff <= s1_prod_o_in;
         s1_prod_s_ff <= s1_prod_s_in;
         s1_dtsq_ff   <= s1_dtsq_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic [23:0]        s2_p_ff,    s2_p_in;
   logic signed [18:0] s2_d_ff,    s2_d_in;
   logic signed [39:0] s2_off_ff,  s2_off_in;
   logic signed [39:0] s2_sens_ff, s2_sens_in;
   logic [17:0]        s2_t2_ff,   s2_t2_in;
   logic               s2_hi_ff,   s2_hi_in;
   logic signed [41:0] t_bias, o_bias, s_bias;
   logic [52:0]        t2h_prod;
   logic [51:0]        t2l_prod;

   always_comb begin
      // bias negative values so the shifts truncate toward zero
      t_bias = s1_prod_t_ff + (s1_prod_t_ff[41] ? 42'sd8388607 : 42'sd0);
      o_bias = s1_prod_o_ff + (s1_prod_o_ff[41] ? 42'sd63 : 42'sd0);
      s_bias = s1_prod_s_ff + (s1_prod_s_ff[41] ? 42'sd127 : 42'sd0);

      s2_p_in  = s1_p_ff;
      s2_d_in  = t_bias[41:23];
      s2_hi_in = !t_bias[41] && (t_bias[41:23] != '0);

      s2_off_in  = $signed({7'b0, coeff.offset, 17'b0})
                 + $signed({{4{o_bias[41]}}, o_bias[41:6]});
      s2_sens_in = $signed({8'b0, coeff.sens, 16'b0})
                 + $signed({{5{s_bias[41]}}, s_bias[41:7]});

      t2h_prod = {5'b0, s1_dtsq_ff} * 53'd5;
      t2l_prod = {4'b0, s1_dtsq_ff} * 52'd3;
      s2_t2_in = s2_hi_in ? {3'b0, t2h_prod[52:38]} : t2l_prod[50:33];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_p_ff    <= s2_p_in;
         s2_d_ff    <= s2_d_in;
         s2_off_ff  <= s2_off_in;
         s2_sens_ff <= s2_sens_in;
         s2_t2_ff   <= s2_t2_in;
         s2_hi_ff   <= s2_hi_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic [23:0]        s3_p_ff,    s3_p_in;
   logic [35:0]        s3_sq_ff,   s3_sq_in;
   logic signed [18:0] s3_temp_ff, s3_temp_in;
   logic signed [39:0] s3_off_ff,  s3_off_in;
   logic signed [39:0] s3_sens_ff, s3_sens_in;
   logic               s3_hi_ff,   s3_hi_in;
   logic signed [37:0] sq_full;

   always_comb begin
      sq_full    = s2_d_ff * s2_d_ff;
      s3_sq_in   = sq_full[35:0];
      s3_temp_in = s2_d_ff + TEMP_BASE - $signed({1'b0, s2_t2_ff});
      s3_p_in    = s2_p_ff;
      s3_off_in  = s2_off_ff;
      s3_sens_in = s2_sens_ff;
      s3_hi_in   = s2_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_p_ff    <= s3_p_in;
         s3_sq_ff   <= s3_sq_in;
         s3_temp_ff <= s3_temp_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_hi_ff   <= s3_hi_in;
      end
   end

   // ---------------------------------------------------------------- stage 4
   logic [23:0]        s4_p_ff,    s4_p_in;
   logic signed [18:0] s4_temp_ff, s4_temp_in;
   logic signed [39:0] s4_off_ff,  s4_off_in;
   logic signed [39:0] s4_sens_ff, s4_sens_in;
   logic [41:0]        off2_prod, sens2_prod;
   logic [37:0]        off2, sens2;

   always_comb begin
      off2_prod  = {6'b0, s3_sq_ff} * 42'd61;
      sens2_prod = {6'b0, s3_sq_ff} * 42'd29;
      // second-order terms apply only at or below the reference temperature
      off2       = s3_hi_ff ? '0 : off2_prod[41:4];
      sens2      = s3_hi_ff ? '0 : sens2_prod[41:4];
      s4_off_in  = s3_off_ff - $signed({2'b0, off2});
      s4_sens_in = s3_sens_ff - $signed({2'b0, sens2});
      s4_p_in    = s3_p_ff;
      s4_temp_in = s3_temp_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_p_ff    <= s4_p_in;
         s4_temp_ff <= s4_temp_in;
         s4_off_ff  <= s4_off_in;
         s4_sens_ff <= s4_sens_in;
      end
   end

   // ---------------------------------------------------------------- stage 5
   logic signed [18:0] s5_temp_ff,  s5_temp_in;
   logic signed [39:0] s5_off_ff,   s5_off_in;
   logic [43:0]        s5_pp_lo_ff, s5_pp_lo_in;
   logic signed [44:0] s5_pp_hi_ff, s5_pp_hi_in;

   always_comb begin
      // split sensitivity into an unsigned low half and a signed high half
      s5_pp_lo_in = {20'b0, s4_p_ff} * {24'b0, s4_sens_ff[19:0]};
      s5_pp_hi_in = $signed({1'b0, s4_p_ff}) * $signed(s4_sens_ff[39:20]);
      s5_temp_in  = s4_temp_ff;
      s5_off_in   = s4_off_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_temp_ff  <= s5_temp_in;
         s5_off_ff   <= s5_off_in;
         s5_pp_lo_ff <= s5_pp_lo_in;
         s5_pp_hi_ff <= s5_pp_hi_in;
      end
   end

   // ---------------------------------------------------------------- stage 6
   logic signed [18:0] s6_temp_ff, s6_temp_in;
   logic signed [39:0] s6_off_ff,  s6_off_in;
   logic signed [43:0] s6_quo_ff,  s6_quo_in;
   logic signed [64:0] p_full, p_bias;

   always_comb begin
      p_full     = $signed({s5_pp_hi_ff, 20'b0}) + $signed({21'b0, s5_pp_lo_ff});
      p_bias     = p_full + (p_full[64] ? 65'sd2097151 : 65'sd0);
      s6_quo_in  = p_bias[64:21];
      s6_temp_in = s5_temp_ff;
      s6_off_in  = s5_off_ff;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_temp_ff <= s6_temp_in;
         s6_off_ff  <= s6_off_in;
         s6_quo_ff  <= s6_quo_in;
      end
   end

   // ---------------------------------------------------------------- stage 7
   logic signed [18:0] s7_temp_ff, s7_temp_in;
   logic [31:0]        s7_pres_ff, s7_pres_in;
   logic signed [44:0] diff, d_bias;

   always_comb begin
      diff       = $signed({s6_quo_ff[43], s6_quo_ff})
                 - $signed({{5{s6_off_ff[39]}}, s6_off_ff});
      d_bias     = diff + (diff[44] ? 45'sd32767 : 45'sd0);
      s7_pres_in = {{2{d_bias[44]}}, d_bias[44:15]};
      s7_temp_in = s6_temp_ff;
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_temp_ff <= s7_temp_in;
         s7_pres_ff <= s7_pres_in;
      end
   end

   assign rsp_tdata = {5'b0, s7_temp_ff, s7_pres_ff};

   // ------------------------------------------------------------- assertions
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted item did not enter the first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && !rsp_tready) |-> !req_tready)
      else $error("input taken while every stage is full and output stalled");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && !en[3]) |=> (v_ff[3] && $stable(s3_temp_ff) && $stable(s3_sq_ff)))
      else $error("stalled middle stage lost or changed its item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("pipeline valid bits not cleared by reset");

endmodule

>>> bench/tb_baro_sensor_second_order_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baro_sensor_second_order_compensation
// Self-checking bench for the barometric second-order compensation block.
// ----------------------------------------------------------------------------
// Raw pressure/temperature pairs go in on the req stream. Each accepted pair
// without a typed-in expectation is run through a bit-exact predictor that
// uses the bench's own copy of the calibration words. The predicted or
// typed-in reading is queued, and each rsp item is checked against the
// oldest queued reading. A short directed table (reset values, field
// extremes, both sides of the temperature branch) comes first. Random pairs
// follow under several calibration settings and sender/receiver idle mixes.
// Calibration words change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_baro_sensor_second_order_compensation
   import bsc_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_PER_SETTING = 67;

   // Indexes past the register list; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [2:0] {
      SET_RESET, SET_TYPICAL, SET_MAX, SET_RANDOM, SET_MIXED
   } setting_kind_type;

   typedef struct packed {
      logic signed [31:0] pressure_comp;
      logic signed [18:0] temperature_centi;
   } comp_result_type;

   typedef struct packed {
      setting_kind_type   setting;
      logic [23:0]        pressure_raw;
      logic [23:0]        temperature_raw;
      logic               literal;
      logic signed [31:0] lit_pressure;
      logic signed [18:0] lit_temperature;
   } vector_type;

   localparam int NUM_DIRECTED = 21;

   // Typical calibration: reference temperature 31553 * 256 = 8077568.
   // Slope 28165 moves t1 off 2000 at 298 counts above the reference.
   // Max calibration: reference 65535 * 256 = 16776960.
   vector_type directed_vectors [0:NUM_DIRECTED-1] = '{
      // All-zero calibration: pressure is 0, temperature is 2000 - 3*t^2/2^33
      '{SET_RESET,   24'd0,        24'd0,        1'b1, 32'sd0, 19'sd2000},
      '{SET_RESET,   24'hFFFFFF,   24'd0,        1'b1, 32'sd0, 19'sd2000},
      '{SET_RESET,   24'd0,        24'hFFFFFF,   1'b1, 32'sd0, -19'sd96303},
      '{SET_RESET,   24'hFFFFFF,   24'hFFFFFF,   1'b1, 32'sd0, -19'sd96303},
      '{SET_RESET,   24'h555555,   24'hAAAAAA,   1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'd0,        24'd0,        1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'hFFFFFF,   24'd0,        1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'd0,        24'hFFFFFF,   1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'hFFFFFF,   24'hFFFFFF,   1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'hAAAAAA,   24'h555555,   1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'h62A8B4,   24'd8077568,  1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'h62A8B4,   24'd8077865,  1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'h62A8B4,   24'd8077866,  1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'h62A8B4,   24'd8077567,  1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'h62A8B4,   24'd8077270,  1'b0, 32'sd0, 19'sd0},
      '{SET_TYPICAL, 24'hFFFFFF,   24'd8077866,  1'b0, 32'sd0, 19'sd0},
      '{SET_MAX,     24'd0,        24'd0,        1'b0, 32'sd0, 19'sd0},
      '{SET_MAX,     24'hFFFFFF,   24'hFFFFFF,   1'b0, 32'sd0, 19'sd0},
      '{SET_MAX,     24'hFFFFFF,   24'd16776960, 1'b0, 32'sd0, 19'sd0},
      '{SET_MAX,     24'hFFFFFF,   24'd16776959, 1'b0, 32'sd0, 19'sd0},
      '{SET_MAX,     24'h800000,   24'h7FFFFF,   1'b0, 32'sd0, 19'sd0}
   };

   setting_kind_type phase_settings [0:5] = '{
      SET_RANDOM, SET_TYPICAL, SET_MIXED, SET_RANDOM, SET_RESET, SET_MIXED
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata  = '0;   // pressure_raw[23:0], temperature_raw[47:24]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [55:0]            rsp_tdata;         // pressure_comp[31:0], temperature_centi[50:32]
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [COEFF_W-1:0]     csr_wdata  = '0;

   // Typed-in expectation traveling with the item on the req side
   logic                   lit_valid  = 1'b0;
   comp_result_type        lit_value  = '0;

   coeff_type              cal = '0;
   comp_result_type        expected_readings [$];
   int                     send_idle_pct = 9;
   int                     rcv_idle_pct  = 76;
   int                     cycle_count = 0;
   int                     mismatches = 0;
   int                     pairs_sent = 0;
   int                     readings_checked = 0;
   int                     settings_loaded = 0;
   setting_kind_type       active_setting = SET_RESET;

   baro_sensor_second_order_compensation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Second-order compensation, all in 64-bit signed, divisions toward zero
   function automatic comp_result_type compensate(logic [23:0] p_raw, logic [23:0] t_raw,
                                                  coeff_type c);
      longint dev, t_first, off_first, sens_first, t_corr, off_corr, sens_corr, d;
      longint pres, temp;
      comp_result_type r;
      dev        = longint'(t_raw) - longint'(c.ref_temp) * 256;
      t_first    = 2000 + (dev * longint'(c.temp_slope)) / 64'sd8388608;
      off_first  = longint'(c.offset) * 131072 + (longint'(c.offset_temp) * dev) / 64;
      sens_first = longint'(c.sens) * 65536 + (longint'(c.sens_temp) * dev) / 128;
      if (t_first > 2000) begin
         t_corr    = (5 * (dev * dev)) / 64'sd274877906944;
         off_corr  = 0;
         sens_corr = 0;
      end else begin
         d         = t_first - 2000;
         t_corr    = (3 * (dev * dev)) / 64'sd8589934592;
         off_corr  = (61 * (d * d)) / 16;
         sens_corr = (29 * (d * d)) / 16;
      end
      temp = t_first - t_corr;
      pres = ((longint'(p_raw) * (sens_first - sens_corr)) / 2097152
              - (off_first - off_corr)) / 32768;
      r.pressure_comp     = pres[31:0];
      r.temperature_centi = temp[18:0];
      return r;
   endfunction

   function automatic coeff_type make_coeffs(setting_kind_type kind);
      coeff_type c;
      c = '0;
      case (kind)
         SET_TYPICAL: begin
            c = '{sens: 16'd46372, offset: 16'd43981, sens_temp: 16'd29059,
                  offset_temp: 16'd27842, ref_temp: 16'd31553, temp_slope: 16'd28165};
         end
         SET_MAX: begin
            c = '1;
         end
         SET_RANDOM: begin
            c = coeff_type'({$urandom, $urandom, $urandom});
         end
         SET_MIXED: begin
            // each word at an end of its range or anywhere in between
            for (int i = 0; i < 6; i++) begin
               case ($urandom_range(2))
                  0: c[i*COEFF_W +: COEFF_W] = '0;
                  1: c[i*COEFF_W +: COEFF_W] = '1;
                  default: c[i*COEFF_W +: COEFF_W] = COEFF_W'($urandom);
               endcase
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   // Hold valid low, wait for every queued reading, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      // let the scoreboard record an item taken at this edge
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [COEFF_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SENS:        cal.sens        = val;
         CSR_OFFSET:      cal.offset      = val;
         CSR_SENS_TEMP:   cal.sens_temp   = val;
         CSR_OFFSET_TEMP: cal.offset_temp = val;
         CSR_REF_TEMP:    cal.ref_temp    = val;
         CSR_TEMP_SLOPE:  cal.temp_slope  = val;
         default: ;  // unused index: dropped
      endcase
   endtask

   task automatic load_setting(setting_kind_type kind);
      coeff_type c;
      c = make_coeffs(kind);
      drain();
      write_csr(CSR_SPARE_LO, COEFF_W'($urandom));
      write_csr(CSR_SENS, c.sens);
      write_csr(CSR_OFFSET, c.offset);
      write_csr(CSR_SENS_TEMP, c.sens_temp);
      write_csr(CSR_OFFSET_TEMP, c.offset_temp);
      write_csr(CSR_REF_TEMP, c.ref_temp);
      write_csr(CSR_TEMP_SLOPE, c.temp_slope);
      write_csr(CSR_SPARE_HI, COEFF_W'($urandom));
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic send_pair(logic [23:0] p_raw, logic [23:0] t_raw, logic literal,
                            comp_result_type lit_r);
      req_tvalid <= 1'b1;
      req_tdata  <= {t_raw, p_raw};
      lit_valid  <= literal;
      lit_value  <= lit_r;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_random_pair();
      logic [23:0] p_raw, t_raw;
      p_raw = 24'($urandom);
      t_raw = 24'($urandom);
      case ($urandom_range(9))
         // near the reference, where the branch flips
         6, 7: t_raw = 24'(int'(cal.ref_temp) * 256 + int'($urandom_range(1200)) - 600);
         8: begin
            p_raw = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            t_raw = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
         end
         default: ;
      endcase
      send_pair(p_raw, t_raw, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Check results first, then queue the prediction for a newly accepted pair
   always @(posedge clock) begin : scoreboard
      comp_result_type    want;
      logic signed [31:0] got_p;
      logic signed [18:0] got_t;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_p = rsp_tdata[31:0];
            got_t = rsp_tdata[50:32];
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result, pressure_comp %0d temperature_centi %0d",
                        $time, got_p, got_t);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               if (got_p !== want.pressure_comp) begin
                  $display("%0t: pressure_comp expected %0d, actual %0d",
                           $time, want.pressure_comp, got_p);
                  mismatches++;
               end
               if (got_t !== want.temperature_centi) begin
                  $display("%0t: temperature_centi expected %0d, actual %0d",
                           $time, want.temperature_centi, got_t);
                  mismatches++;
               end
               readings_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (lit_valid)
               expected_readings.push_back(lit_value);
            else
               expected_readings.push_back(compensate(req_tdata[23:0], req_tdata[47:24], cal));
            pairs_sent++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d readings still outstanding",
                  $time, expected_readings.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_vectors[i]) begin
         if (directed_vectors[i].setting != active_setting) begin
            load_setting(directed_vectors[i].setting);
            active_setting = directed_vectors[i].setting;
         end
         send_pair(directed_vectors[i].pressure_raw, directed_vectors[i].temperature_raw,
                   directed_vectors[i].literal,
                   comp_result_type'{directed_vectors[i].lit_pressure,
                                     directed_vectors[i].lit_temperature});
      end

      for (int m = 0; m < 3; m++) begin
         send_idle_pct = (m == 0) ? 9 : (m == 1) ? 76 : 0;
         rcv_idle_pct  = (m == 0) ? 76 : (m == 1) ? 9 : 0;
         for (int s = 0; s < 2; s++) begin
            load_setting(phase_settings[m*2 + s]);
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
               // stop feeding mid-run until the pipeline empties
               if (s == 0 && n == RANDOM_PER_SETTING / 2) drain();
               send_random_pair();
            end
         end
      end

      drain();
      if (expected_readings.size() != 0) begin
         $display("%0t: %0d expected readings never arrived", $time, expected_readings.size());
         mismatches++;
      end
      $display("Sent %0d raw pairs, checked %0d compensated readings, %0d calibration loads.",
               pairs_sent, readings_checked, settings_loaded);
      $display("Covered zero, typical, max and random calibration under three idle mixes.");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
